/* hdl/ldf_pkg.sv */
package ldf_pkg;

  // Width of the payload byte counter; header lengths above its range saturate.
  localparam int LENGTH_WIDTH = 32;

  localparam int HEADER_BYTES = 8;
  localparam int HC_W         = 4;
  localparam logic [HC_W-1:0] HC_PAYLOAD = HC_W'(HEADER_BYTES);
  localparam logic [HC_W-1:0] HC_START   = '0;
  localparam logic [HC_W-1:0] HC_TYPE0   = 4'd4;

  localparam logic [31:0] LENGTH_LIMIT = 32'((64'd1 << LENGTH_WIDTH) - 64'd1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_DATA_W  = 72;

  typedef struct packed {
    logic [31:0] msg_length;
    logic [31:0] frame_type;
    logic [7:0]  payload_byte;
    logic        is_last;
    logic        is_empty;
  } ldf_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ldf_qstat_t;

endpackage

/* hdl/ldf_front.sv */
module ldf_front
  import ldf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] rx_byte
  input  ldf_qstat_t q_stat,
  output logic       push,
  output ldf_entry_t push_entry
);

  logic [HC_W-1:0]         header_count_r, header_count_nxt;
  logic [31:0]             length_word_r, length_word_nxt;
  logic [31:0]             type_word_r, type_word_nxt;
  logic [LENGTH_WIDTH-1:0] bytes_remaining_r, bytes_remaining_nxt;

  logic                    accept;
  logic [HC_W-1:0]         hc, hc_inc;
  logic [31:0]             len_base, type_base, len_sat;
  logic [LENGTH_WIDTH-1:0] left;
  logic                    res_valid;
  ldf_entry_t              res;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    hc = header_count_r;
    if (hc > HC_PAYLOAD || (hc == HC_PAYLOAD && bytes_remaining_r == '0)) begin
      hc = HC_START;
    end
    hc_inc    = hc + 4'd1;
    left      = bytes_remaining_r - LENGTH_WIDTH'(1);
    len_base  = (hc == HC_START) ? 32'd0 : length_word_r;
    type_base = (hc == HC_START) ? 32'd0 : type_word_r;
    len_sat   = '0;

    header_count_nxt    = header_count_r;
    length_word_nxt     = length_word_r;
    type_word_nxt       = type_word_r;
    bytes_remaining_nxt = bytes_remaining_r;
    res_valid           = 1'b0;
    res                 = '0;

    if (hc == HC_PAYLOAD) begin
      res_valid           = 1'b1;
      res.payload_byte    = in_tdata;
      res.frame_type      = type_word_r;
      res.msg_length      = length_word_r;
      res.is_last         = (left == '0);
      bytes_remaining_nxt = left;
      header_count_nxt    = (left == '0) ? HC_START : HC_PAYLOAD;
    end else begin
      length_word_nxt = len_base;
      type_word_nxt   = type_base;
      if (hc < HC_TYPE0) begin
        length_word_nxt = len_base | ({24'd0, in_tdata} << {hc[1:0], 3'd0});
      end else begin
        type_word_nxt = type_base | ({24'd0, in_tdata} << {hc[1:0], 3'd0});
      end
      if (hc_inc < HC_PAYLOAD) begin
        header_count_nxt = hc_inc;
      end else begin
        // header done: clamp length to counter range
        len_sat         = (length_word_nxt > LENGTH_LIMIT) ? LENGTH_LIMIT : length_word_nxt;
        length_word_nxt = len_sat;
        if (len_sat == '0) begin
          res_valid           = 1'b1;
          res.frame_type      = type_word_nxt;
          res.msg_length      = '0;
          res.is_last         = 1'b1;
          res.is_empty        = 1'b1;
          bytes_remaining_nxt = '0;
          header_count_nxt    = HC_START;
        end else begin
          bytes_remaining_nxt = len_sat[LENGTH_WIDTH-1:0];
          header_count_nxt    = HC_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r    <= '0;
      length_word_r     <= '0;
      type_word_r       <= '0;
      bytes_remaining_r <= '0;
    end else if (accept) begin
      header_count_r    <= header_count_nxt;
      length_word_r     <= length_word_nxt;
      type_word_r       <= type_word_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
    end
  end

  assign push       = accept && res_valid;
  assign push_entry = res;

endmodule

/* hdl/ldf_queue.sv */
module ldf_queue
  import ldf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ldf_entry_t push_entry,
  input  logic       pop,
  output ldf_entry_t pop_entry,
  output ldf_qstat_t q_stat
);

  ldf_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry    = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

/* hdl/ldf_back.sv */
module ldf_back
  import ldf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ldf_qstat_t            q_stat,
  input  ldf_entry_t            pop_entry,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] payload_byte, [39:8] frame_type,
                                            // [71:40] msg_length
  output logic                  out_tlast,  // is_last
  output logic                  out_tuser   // is_empty
);

  logic       out_valid_r;
  ldf_entry_t out_entry_r;

  assign pop = !q_stat.empty && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_entry_r <= pop_entry;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_entry_r.msg_length, out_entry_r.frame_type, out_entry_r.payload_byte};
  assign out_tlast  = out_entry_r.is_last;
  assign out_tuser  = out_entry_r.is_empty;

endmodule

/* hdl/length_prefixed_deframer.sv */
// Length-prefixed message deframer. Takes a byte stream, one byte per request,
// and splits it into messages that each start with an 8-byte header: payload
// length (bytes 0..3, little-endian) then message type (bytes 4..7,
// little-endian). Header bytes give no output. Each payload byte comes out as
// one request carrying the byte, the message type and the length, with tlast
// on the final byte. A zero-length message gives one request with data byte 0,
// tlast and tuser (empty) set. Lengths above the counter range (LENGTH_WIDTH
// in the package) saturate, and the saturated value is what is reported.
// Throughput is one byte per clock while the queue has room (in_tready drops
// when it is full): the header parser updates its counters for each byte.
// A result is registered in the 2-entry queue and then in the output register
// before out_tvalid rises; the queue lets the input keep flowing while a
// result waits on out_tready.
module length_prefixed_deframer
  import ldf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] payload_byte, [39:8] frame_type,
                                            // [71:40] msg_length
  output logic                  out_tlast,  // is_last
  output logic                  out_tuser   // is_empty
);

  ldf_qstat_t q_stat;
  logic       push, pop;
  ldf_entry_t push_entry, pop_entry;

  // front: header parsing and classification of each byte
  ldf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue between parser and output stage
  ldf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  // back: output register toward the result stream
  ldf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("deframer queue overflow");

  // never popped while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("deframer queue underflow");

  // an empty-message result is always last with a zero data byte
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata[7:0] == 8'd0))
    else $error("malformed empty-message result");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

/* test/deframe_predictor_pkg.sv */
package deframe_predictor_pkg;
  import ldf_pkg::*;

  class deframe_predictor;
    logic [HC_W-1:0] hdr_count;
    logic [31:0]     len_word;
    logic [31:0]     type_word;
    logic [31:0]     remaining;
    ldf_entry_t      due_results[$];
    int              mismatches;
    int              checked;
    int              frames;
    int              empties;

    function new();
      hdr_count   = HC_START;
      len_word    = '0;
      type_word   = '0;
      remaining   = '0;
      mismatches  = 0;
      checked     = 0;
      frames      = 0;
      empties     = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Accepted stream byte: advance the framing state, queue any result it causes.
    function void take_stream_byte(logic [7:0] b);
      logic [HC_W-1:0] hc;
      ldf_entry_t      e;
      hc = hdr_count;
      // out-of-range count, or payload phase with nothing due: new header
      if (hc > HC_PAYLOAD || (hc == HC_PAYLOAD && remaining == 0))
        hc = HC_START;
      if (hc == HC_PAYLOAD) begin
        remaining      = remaining - 1;
        e.payload_byte = b;
        e.frame_type   = type_word;
        e.msg_length   = len_word;
        e.is_last      = (remaining == 0);
        e.is_empty     = 1'b0;
        due_results    = {due_results, e};
        hdr_count = e.is_last ? HC_START : HC_PAYLOAD;
        return;
      end
      if (hc == HC_START) begin
        len_word  = '0;
        type_word = '0;
      end
      if (hc < HC_TYPE0)
        len_word = len_word | (32'(b) << (8 * hc));
      else
        type_word = type_word | (32'(b) << (8 * (hc - HC_TYPE0)));
      hc = hc + 1'b1;
      if (hc < HC_PAYLOAD) begin
        hdr_count = hc;
        return;
      end
      if (len_word > LENGTH_LIMIT)
        len_word = LENGTH_LIMIT;
      frames++;
      if (len_word == 0) begin
        e.payload_byte = '0;
        e.frame_type   = type_word;
        e.msg_length   = len_word;
        e.is_last      = 1'b1;
        e.is_empty     = 1'b1;
        due_results    = {due_results, e};
        empties++;
        remaining = '0;
        hdr_count = HC_START;
      end else begin
        remaining = len_word;
        hdr_count = HC_PAYLOAD;
      end
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < 40)
        $display("MISMATCH %s: got %h, want %h", what, got, want);
      mismatches++;
    endtask

    // Accepted output request: compare against the oldest queued result.
    task check_out_request(logic [OUT_DATA_W-1:0] data, logic last, logic user);
      ldf_entry_t e;
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected request", data[31:0], '0);
        return;
      end
      e = due_results.pop_front();
      checked++;
      if (data[7:0] !== e.payload_byte)
        flag_mismatch("payload_byte", 32'(data[7:0]), 32'(e.payload_byte));
      if (data[39:8] !== e.frame_type)
        flag_mismatch("frame_type", data[39:8], e.frame_type);
      if (data[71:40] !== e.msg_length)
        flag_mismatch("msg_length", data[71:40], e.msg_length);
      if (last !== e.is_last)
        flag_mismatch("is_last", 32'(last), 32'(e.is_last));
      if (user !== e.is_empty)
        flag_mismatch("is_empty", 32'(user), 32'(e.is_empty));
    endtask
  endclass

endpackage

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ldf_pkg::*;
  import deframe_predictor_pkg::*;

  localparam int STREAM_BYTES  = 1650;  // random stream stops after this many bytes
  localparam int WATCHDOG_MAX  = 2000;  // cycles without any accepted request
  localparam int DRAIN_CYCLES  = 10;    // extra wait after the last result is checked
  localparam int HOLD_CYCLES   = 80;    // long receiver back-pressure stretch

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  deframe_predictor frame_model;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          bytes_sent;
  int          quiet_cycles;
  bit          hold_request;

  length_prefixed_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Monitor: both channels sampled at the rising edge, before any NBA lands,
  // so the values seen are the ones the handshake used. Input requests feed
  // the model; output requests are checked against it. The watchdog counts
  // edges where neither side moved a request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        frame_model.take_stream_byte(in_tdata);
      if (out_tvalid && out_tready)
        frame_model.check_out_request(out_tdata, out_tlast, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("Watchdog: no request moved for %0d cycles", WATCHDOG_MAX);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, or a long hold-off when asked for one.
  // The hold-off is counted here so the sender keeps offering bytes meanwhile
  // and the internal queue fills up until in_tready drops.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // One stream byte: optional idle gap with tvalid low, then hold the
  // request until the edge where in_tready is seen high.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Header (length then type, both little-endian) followed by the payload.
  // fill < 0 gives random payload bytes, otherwise every byte is fill.
  task automatic send_frame(input logic [31:0] len, input logic [31:0] mtype,
                            input int fill);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(mtype[8*i +: 8]);
    for (int unsigned i = 0; i < len; i++)
      send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  initial begin
    logic [31:0]  len;
    logic [31:0]  mtype;
    int unsigned  pick;
    bit           held;

    frame_model   = new();
    send_idle_pct = 8;
    recv_idle_pct = 55;
    bytes_sent    = 0;
    quiet_cycles  = 0;
    hold_request  = 1'b0;
    held          = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message with all-ones type, payload extremes under a
    // zero type, then a single-byte message (first byte is also the last).
    send_frame(32'd0, 32'hFFFF_FFFF, 0);
    send_byte(8'h02); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'hFF);
    send_frame(32'd1, 32'hA55A_3CC3, 8'h80);

    // Random framed traffic. Mostly short messages, some empty, a few long
    // enough to use the second length byte. Idling changes by thirds.
    while (bytes_sent < STREAM_BYTES) begin
      if (bytes_sent >= 2 * STREAM_BYTES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (bytes_sent >= STREAM_BYTES / 3) begin
        send_idle_pct = 55;
        recv_idle_pct = 8;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15)       len = 32'd0;
      else if (pick < 90)  len = $urandom_range(1, 16);
      else if (pick < 97)  len = $urandom_range(17, 64);
      else                 len = $urandom_range(256, 300);
      pick = $urandom_range(0, 9);
      if (pick == 0)       mtype = 32'h0;
      else if (pick == 1)  mtype = 32'hFFFF_FFFF;
      else                 mtype = $urandom;
      // Once in the no-idle third: stall the receiver for a long stretch
      // while a longer message streams in, so the input backs up.
      if (!held && send_idle_pct == 0) begin
        held         = 1'b1;
        hold_request = 1'b1;
        len          = 32'd40;
      end
      send_frame(len, mtype, -1);
    end

    in_tvalid <= 1'b0;
    while (frame_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes as %0d messages (%0d empty); %0d output requests checked.",
             bytes_sent, frame_model.frames, frame_model.empties, frame_model.checked);
    $display("Idling: sender-light, receiver-light, none; one %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (frame_model.mismatches == 0 && frame_model.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* length_prefixed_deframer.f */
hdl/ldf_pkg.sv
hdl/ldf_front.sv
hdl/ldf_queue.sv
hdl/ldf_back.sv
hdl/length_prefixed_deframer.sv
test/deframe_predictor_pkg.sv
test/testbench.sv
